// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_byte;    // store data byte at fill
    logic       start_msg;  // reload iv, clear counters
    logic       load;       // window and working words from buffer and chain
    logic       round;      // one round
    logic       fold;       // chain += working
    logic       pad_first;  // write padding into current buffer
    logic       pad_len;    // clear buffer and write length only (second block)
    logic       pad_tail;   // write length in last 8 bytes
    logic [5:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

endpackage

// ===== rtl/core/sha256_datapath.sv =====
module sha256_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::cmd_t    cmd,
  input  logic [7:0]          data_byte,
  input  logic [2:0]          out_sel,
  output sha256_pkg::status_t status,
  output logic [31:0]         out_word
);

  // block buffer held as sixteen big-endian words
  logic [31:0] buffer [16];
  logic [31:0] chain [8];
  logic [31:0] wnd [16];
  logic [31:0] v [8];
  logic [5:0]  fill;
  logic [60:0] count;
  logic [63:0] bits;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0, s1, wnew, w, t1, t2;

  always_comb begin
    s0 = rotr(wnd[1], 7) ^ rotr(wnd[1], 18) ^ (wnd[1] >> 3);
    s1 = rotr(wnd[14], 17) ^ rotr(wnd[14], 19) ^ (wnd[14] >> 10);
    wnew = wnd[0] + s0 + wnd[9] + s1;
    // window shifts so slot 0 holds the current word for rounds 0 to 15; later rounds use wnew
    w = (cmd.rnd < 6'd16) ? wnd[0] : wnew;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[cmd.rnd] + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign bits = {count, 3'b000};
  assign status.fill = fill;
  assign out_word = chain[out_sel];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (cmd.wr_byte && 6'(4*i + j) == fill) begin
          buffer[i][8*(3-j) +: 8] <= data_byte;
        end else if (cmd.pad_tail && 6'(4*i + j) >= sha256_pkg::LEN_START) begin
          buffer[i][8*(3-j) +: 8] <= bits[8*(63 - 4*i - j) +: 8];
        end else if (cmd.pad_first && 6'(4*i + j) == fill) begin
          buffer[i][8*(3-j) +: 8] <= sha256_pkg::PAD_BYTE;
        end else if ((cmd.pad_first && 6'(4*i + j) > fill) ||
                     (cmd.pad_len && 6'(4*i + j) < sha256_pkg::LEN_START)) begin
          buffer[i][8*(3-j) +: 8] <= 8'h00;
        end
      end
    end
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) wnd[i] <= buffer[i];
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end
    if (cmd.round) begin
      if (cmd.rnd < 6'd16) begin
        for (int i = 0; i < 15; i++) wnd[i] <= wnd[i+1];
        wnd[15] <= wnd[0];
      end else begin
        for (int i = 0; i < 15; i++) wnd[i] <= wnd[i+1];
        wnd[15] <= wnew;
      end
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_msg) begin
      fill  <= '0;
      count <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::INIT_H[i];
    end else begin
      if (cmd.wr_byte) begin
        fill  <= fill + 6'd1;
        count <= count + 61'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
    end
  end

endmodule

// ===== rtl/core/sha256_ctrl.sv =====
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                byte_present,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_sel,
  input  sha256_pkg::status_t status,
  output sha256_pkg::cmd_t    cmd
);

  sha256_pkg::state_t state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       fin, fin_next;      // closing the message
  logic       two, two_next;      // length goes into an extra block
  logic       acc;
  // set once the padding block of this message has been built
  logic       pad_done;

  assign acc = in_valid && in_ready;
  assign out_sel = widx;

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    widx_next = widx;
    fin_next = fin;
    two_next = two;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (acc) begin
          fin_next = end_of_message;
          if (byte_present && status.fill == 6'd63) state_next = sha256_pkg::ST_LOAD;
          else if (end_of_message) state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        two_next = status.fill >= sha256_pkg::LEN_START;
        state_next = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_LOAD: begin
        rnd_next = '0;
        state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        rnd_next = rnd + 6'd1;
        if (rnd == 6'd63) state_next = sha256_pkg::ST_FOLD;
      end
      sha256_pkg::ST_FOLD: begin
        if (!fin) state_next = sha256_pkg::ST_IDLE;
        else if (two) begin
          two_next = 1'b0;
          state_next = sha256_pkg::ST_LOAD;
        end else if (status.fill == 6'd0 && !pad_done) begin
          // a full block with end mark: pad after the fold (fill is zero then)
          state_next = sha256_pkg::ST_PAD;
        end else begin
          widx_next = '0;
          state_next = sha256_pkg::ST_OUT;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rnd = rnd;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.wr_byte = acc && byte_present;
      end
      sha256_pkg::ST_PAD: begin
        cmd.pad_first = 1'b1;
        cmd.pad_tail = status.fill < sha256_pkg::LEN_START;
      end
      sha256_pkg::ST_LOAD: cmd.load = 1'b1;
      sha256_pkg::ST_ROUND: cmd.round = 1'b1;
      sha256_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (two) begin
          cmd.pad_len = 1'b1;
          cmd.pad_tail = 1'b1;
        end
      end
      sha256_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.start_msg = out_ready && widx == 3'd7;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      rnd <= '0;
      widx <= '0;
      fin <= 1'b0;
      two <= 1'b0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      widx <= widx_next;
      fin <= fin_next;
      two <= two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state == sha256_pkg::ST_IDLE) pad_done <= 1'b0;
    else if (state == sha256_pkg::ST_PAD) pad_done <= 1'b1;
  end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_top.sv =====
// SHA-256 over a byte stream. Each accepted request carries at most one
// message byte; a request with end_of_message closes the message, pads it and
// then the eight digest words come out in order, word_index 0 first, after
// which the block is ready for a new message. A byte request is stored at
// once; the one that completes a 64-byte block is then compressed by the
// single round unit (load, 64 rounds, fold). Closing a message adds one or
// two such compressions plus a padding step, then eight output requests.
// Input is not taken while a block is compressed or the digest is out.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic [2:0]          sel;

  sha256_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .byte_present, .end_of_message,
    .out_valid, .out_ready, .out_sel(sel), .status, .cmd
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .data_byte, .out_sel(sel), .status, .out_word(digest_word)
  );

  assign word_index = sel;
  assign last_word = sel == 3'd7;

endmodule
